// ----- src/rbd_pkg.sv -----
package rbd_pkg;

  localparam int NP_W   = 13;
  localparam int DIM_W  = 16;
  localparam int RANK_W = 12;

  localparam int MAX_WORKERS    = 4096;
  localparam int MAX_RASTER_DIM = 65535;

  localparam int ROOT_W = ($clog2(MAX_WORKERS + 1) + 1) / 2;
  localparam int BIT_W  = $clog2(ROOT_W);

  localparam int DIV_N  = DIM_W;
  localparam int DIVC_W = $clog2(DIV_N + 1);

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 96;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WORKER_COUNT  = 2'd0,
    REG_RASTER_WIDTH  = 2'd1,
    REG_RASTER_HEIGHT = 2'd2,
    REG_SPLIT_MODE    = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_START,
    OP_DIV_TAKE,
    OP_PLACE,
    OP_LOAD,
    OP_LOAD_ERR
  } op_e;

  typedef enum logic [1:0] {
    DIV_SEARCH,
    DIV_WIDTH,
    DIV_HEIGHT,
    DIV_RANK
  } div_sel_e;

  typedef struct packed {
    op_e      op;
    div_sel_e sel;
  } cmd_t;

  typedef struct packed {
    logic rank_err;
    logic dirty;
    logic sqrt_last;
    logic div_done;
    logic search_hit;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic [NP_W-1:0]  grid_rows;
    logic [NP_W-1:0]  grid_cols;
    logic [DIM_W-1:0] size_y;
    logic [DIM_W-1:0] size_x;
    logic [DIM_W-1:0] offset_y;
    logic [DIM_W-1:0] offset_x;
    logic             rank_error;
  } res_t;

endpackage

// ----- src/rbd_divider.sv -----
module rbd_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rbd_pkg::DIV_N-1:0] dividend_i,
  input  logic [rbd_pkg::NP_W-1:0]  divisor_i,
  output logic                      done_o,
  output logic [rbd_pkg::DIV_N-1:0] quot_o,
  output logic [rbd_pkg::NP_W-1:0]  rem_o
);
  import rbd_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DIVC_W-1:0] cnt_q, cnt_d;
  logic [DIV_N-1:0]  dvd_q, dvd_d;
  logic [NP_W-1:0]   dsr_q, dsr_d;
  logic [NP_W-1:0]   rem_q, rem_d;
  logic [NP_W:0]     shifted;
  logic              fits;

  assign shifted = {rem_q, dvd_q[DIV_N-1]};
  assign fits    = shifted >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIVC_W'(DIV_N);
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? NP_W'(shifted - {1'b0, dsr_q}) : shifted[NP_W-1:0];
      dvd_d = {dvd_q[DIV_N-2:0], fits};
      cnt_d = cnt_q - DIVC_W'(1);
      if (cnt_q == DIVC_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;

endmodule

// ----- src/rbd_datapath.sv -----
module rbd_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rbd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rbd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [rbd_pkg::RANK_W-1:0]     rank_i,
  input  rbd_pkg::cmd_t                  cmd_i,
  output rbd_pkg::sts_t                  sts_o,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output rbd_pkg::res_t                  res_o
);
  import rbd_pkg::*;

  typedef struct packed {
    logic [DIM_W-1:0] off;
    logic [DIM_W-1:0] size;
  } place_t;

  function automatic place_t place(input logic [NP_W-1:0] idx, input logic [NP_W-1:0] nblk,
                                   input logic [DIM_W-1:0] base, input logic [NP_W-1:0] rem,
                                   input logic mode);
    place_t                 p;
    logic [NP_W+DIM_W-1:0]  prod;
    logic [NP_W-1:0]        lo;
    prod = (NP_W+DIM_W)'(idx) * (NP_W+DIM_W)'(base);
    lo   = (idx < rem) ? idx : rem;
    if (!mode) begin
      p.off  = prod[DIM_W-1:0];
      p.size = base + ((idx == nblk - NP_W'(1)) ? DIM_W'(rem) : '0);
    end else begin
      p.off  = prod[DIM_W-1:0] + DIM_W'(lo);
      p.size = base + ((idx < rem) ? DIM_W'(1) : '0);
    end
    return p;
  endfunction

  logic [NP_W-1:0]    worker_count_q;
  logic [DIM_W-1:0]   width_q, height_q;
  logic               mode_q;
  logic               dirty_q;
  logic [NP_W-1:0]    np_sat;
  logic [DIM_W-1:0]   w_sat, h_sat;

  logic [RANK_W-1:0]  rank_q;
  logic [NP_W-1:0]    rows_q, cols_q;
  logic [BIT_W-1:0]   bit_q;
  logic [DIM_W-1:0]   base_x_q, base_y_q;
  logic [NP_W-1:0]    rem_x_q, rem_y_q;
  logic [NP_W-1:0]    bx_q, by_q;
  place_t             px_q, py_q;
  logic               out_valid_q;
  res_t               res_q;

  logic [ROOT_W-1:0]   trial;
  logic [2*ROOT_W-1:0] trial_sq;

  logic               div_start;
  logic [DIV_N-1:0]   div_dividend;
  logic [NP_W-1:0]    div_divisor;
  logic               div_done;
  logic [DIV_N-1:0]   div_quot;
  logic [NP_W-1:0]    div_rem;

  assign np_sat = (worker_count_q > NP_W'(MAX_WORKERS)) ? NP_W'(MAX_WORKERS) : worker_count_q;
  assign w_sat  = (width_q > DIM_W'(MAX_RASTER_DIM)) ? DIM_W'(MAX_RASTER_DIM) : width_q;
  assign h_sat  = (height_q > DIM_W'(MAX_RASTER_DIM)) ? DIM_W'(MAX_RASTER_DIM) : height_q;

  assign trial    = rows_q[ROOT_W-1:0] | (ROOT_W'(1) << bit_q);
  assign trial_sq = (2*ROOT_W)'(trial) * (2*ROOT_W)'(trial);

  always_comb begin
    case (cmd_i.sel)
      DIV_SEARCH: begin
        div_dividend = DIV_N'(np_sat);
        div_divisor  = rows_q;
      end
      DIV_WIDTH: begin
        div_dividend = w_sat;
        div_divisor  = cols_q;
      end
      DIV_HEIGHT: begin
        div_dividend = h_sat;
        div_divisor  = rows_q;
      end
      default: begin
        div_dividend = DIV_N'(rank_q);
        div_divisor  = cols_q;
      end
    endcase
  end

  assign div_start = (cmd_i.op == OP_DIV_START);

  rbd_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      worker_count_q <= NP_W'(1);
      width_q        <= DIM_W'(1);
      height_q       <= DIM_W'(1);
      mode_q         <= 1'b0;
      dirty_q        <= 1'b1;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dirty_q <= 1'b1;
        case (reg_idx_e'(cfg_index_i))
          REG_WORKER_COUNT:  worker_count_q <= cfg_data_i[NP_W-1:0];
          REG_RASTER_WIDTH:  width_q        <= cfg_data_i[DIM_W-1:0];
          REG_RASTER_HEIGHT: height_q       <= cfg_data_i[DIM_W-1:0];
          REG_SPLIT_MODE:    mode_q         <= cfg_data_i[0];
          default: ;
        endcase
      end else if (cmd_i.op == OP_DIV_TAKE && cmd_i.sel == DIV_HEIGHT) begin
        dirty_q <= 1'b0;
      end
      if (cmd_i.op == OP_LOAD || cmd_i.op == OP_LOAD_ERR) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_ACCEPT: rank_q <= rank_i;
      OP_SQRT_INIT: begin
        rows_q <= '0;
        bit_q  <= BIT_W'(ROOT_W - 1);
      end
      OP_SQRT_STEP: begin
        if (trial_sq <= (2*ROOT_W)'(np_sat)) rows_q <= NP_W'(trial);
        bit_q <= bit_q - BIT_W'(1);
      end
      OP_DIV_TAKE: begin
        case (cmd_i.sel)
          DIV_SEARCH: begin
            cols_q <= div_quot[NP_W-1:0];
            if (!sts_o.search_hit) rows_q <= rows_q - NP_W'(1);
          end
          DIV_WIDTH: begin
            base_x_q <= div_quot;
            rem_x_q  <= div_rem;
          end
          DIV_HEIGHT: begin
            base_y_q <= div_quot;
            rem_y_q  <= div_rem;
          end
          default: begin
            bx_q <= div_rem;
            by_q <= div_quot[NP_W-1:0];
          end
        endcase
      end
      OP_PLACE: begin
        px_q <= place(bx_q, cols_q, base_x_q, rem_x_q, mode_q);
        py_q <= place(by_q, rows_q, base_y_q, rem_y_q, mode_q);
      end
      OP_LOAD: begin
        res_q.offset_x   <= px_q.off;
        res_q.offset_y   <= py_q.off;
        res_q.size_x     <= px_q.size;
        res_q.size_y     <= py_q.size;
        res_q.grid_cols  <= cols_q;
        res_q.grid_rows  <= rows_q;
        res_q.rank_error <= 1'b0;
      end
      OP_LOAD_ERR: begin
        res_q.offset_x   <= '0;
        res_q.offset_y   <= '0;
        res_q.size_x     <= '0;
        res_q.size_y     <= '0;
        res_q.grid_cols  <= '0;
        res_q.grid_rows  <= '0;
        res_q.rank_error <= 1'b1;
      end
      default: ;
    endcase
  end

  assign sts_o.rank_err   = NP_W'(rank_q) >= np_sat;
  assign sts_o.dirty      = dirty_q;
  assign sts_o.sqrt_last  = (bit_q == '0);
  assign sts_o.div_done   = div_done;
  assign sts_o.search_hit = (rows_q == NP_W'(1)) || (div_rem == '0);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

// ----- src/rbd_ctrl.sv -----
module rbd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rbd_pkg::sts_t sts_i,
  output rbd_pkg::cmd_t cmd_o
);
  import rbd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SQRT,
    ST_SRCH_GO,
    ST_SRCH_WAIT,
    ST_W_GO,
    ST_W_WAIT,
    ST_H_GO,
    ST_H_WAIT,
    ST_R_GO,
    ST_R_WAIT,
    ST_PLACE,
    ST_LOAD,
    ST_LOAD_ERR
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    cmd_o.sel  = DIV_RANK;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          state_d  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.rank_err) begin
          state_d = ST_LOAD_ERR;
        end else if (sts_i.dirty) begin
          cmd_o.op = OP_SQRT_INIT;
          state_d  = ST_SQRT;
        end else begin
          state_d = ST_R_GO;
        end
      end
      ST_SQRT: begin
        cmd_o.op = OP_SQRT_STEP;
        if (sts_i.sqrt_last) state_d = ST_SRCH_GO;
      end
      ST_SRCH_GO: begin
        cmd_o.op  = OP_DIV_START;
        cmd_o.sel = DIV_SEARCH;
        state_d   = ST_SRCH_WAIT;
      end
      ST_SRCH_WAIT: begin
        cmd_o.sel = DIV_SEARCH;
        if (sts_i.div_done) begin
          cmd_o.op = OP_DIV_TAKE;
          state_d  = sts_i.search_hit ? ST_W_GO : ST_SRCH_GO;
        end
      end
      ST_W_GO: begin
        cmd_o.op  = OP_DIV_START;
        cmd_o.sel = DIV_WIDTH;
        state_d   = ST_W_WAIT;
      end
      ST_W_WAIT: begin
        cmd_o.sel = DIV_WIDTH;
        if (sts_i.div_done) begin
          cmd_o.op = OP_DIV_TAKE;
          state_d  = ST_H_GO;
        end
      end
      ST_H_GO: begin
        cmd_o.op  = OP_DIV_START;
        cmd_o.sel = DIV_HEIGHT;
        state_d   = ST_H_WAIT;
      end
      ST_H_WAIT: begin
        cmd_o.sel = DIV_HEIGHT;
        if (sts_i.div_done) begin
          cmd_o.op = OP_DIV_TAKE;
          state_d  = ST_R_GO;
        end
      end
      ST_R_GO: begin
        cmd_o.op = OP_DIV_START;
        state_d  = ST_R_WAIT;
      end
      ST_R_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.op = OP_DIV_TAKE;
          state_d  = ST_PLACE;
        end
      end
      ST_PLACE: begin
        cmd_o.op = OP_PLACE;
        state_d  = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_IDLE;
        end
      end
      ST_LOAD_ERR: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_LOAD_ERR;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

// ----- src/raster_block_decomposition_unit.sv -----
// An in-range rank runs the rank division and placement while the grid setup is current.
// After any configuration write the next word also runs the setup: the square root, then
// one division per factor trial (1 to 64 trials) and the two raster divisions.
// All divisions share one 16-step iterative divider; words are taken one at a time.
// A result may wait in the output register while the next word is accepted.
// Reset: registers return to 1 worker, 1 x 1 raster, mode 0; setup is marked stale.
module raster_block_decomposition_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rbd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [rbd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // worker_rank[11:0]
  input  logic [rbd_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // offset_x[15:0], offset_y[31:16], size_x[47:32], size_y[63:48],
  // grid_cols[76:64], grid_rows[89:77]
  output logic [rbd_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  // rank_error[0]
  output logic                            m_axis_tuser_o
);
  import rbd_pkg::*;

  cmd_t cmd;
  sts_t sts;
  res_t res;

  rbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rbd_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rank_i      (s_axis_tdata_i[RANK_W-1:0]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .res_o       (res)
  );

  assign m_axis_tdata_o = {
    (OUT_DATA_W - 2*NP_W - 4*DIM_W)'(0),
    res.grid_rows, res.grid_cols, res.size_y, res.size_x, res.offset_y, res.offset_x
  };
  assign m_axis_tuser_o = res.rank_error;

endmodule

// ----- src/rbd_checker.sv -----
module rbd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [rbd_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  input logic                            m_axis_tuser_o
);
  import rbd_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("result word dropped while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("error result carries nonzero fields");

  a_grid_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |->
      (m_axis_tdata_o[4*DIM_W +: NP_W] != '0) && (m_axis_tdata_o[4*DIM_W+NP_W +: NP_W] != '0))
    else $error("valid result with empty grid");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input taken while previous word still in work");

endmodule

bind raster_block_decomposition_unit rbd_checker u_rbd_checker (.*);

// ----- sim/raster_block_decomposition_unit_test.sv -----
`timescale 1ns / 1ps

module raster_block_decomposition_unit_test;
  import rbd_pkg::*;

  localparam int PERIOD         = 20;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 60;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tuser_o;

  logic [NP_W-1:0]  cfg_workers;
  logic [DIM_W-1:0] cfg_width;
  logic [DIM_W-1:0] cfg_height;
  logic             cfg_split;

  res_t expected_blocks[$];
  int   mismatches;
  int   words_sent;
  int   error_words;
  int   config_phases;
  int   idle_cycles = 0;
  int   stall_left  = 0;
  bit   quiet;

  raster_block_decomposition_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(PERIOD / 2) clk_i = ~clk_i;
  end

  function automatic void place_block(input int idx, input int nblk, input int dim,
                                      input logic mode, output int off, output int len);
    int base;
    int rem;
    base = dim / nblk;
    rem  = dim % nblk;
    if (!mode) begin
      off = idx * base;
      len = base + ((idx == nblk - 1) ? rem : 0);
    end else begin
      off = idx * base + ((idx < rem) ? idx : rem);
      len = base + ((idx < rem) ? 1 : 0);
    end
  endfunction

  function automatic int active_workers();
    int np;
    np = cfg_workers;
    if (np > MAX_WORKERS) np = MAX_WORKERS;
    return np;
  endfunction

  function automatic res_t predict_block(input logic [RANK_W-1:0] rank);
    res_t r;
    int   np, w, h, rows, cols, ox, oy, sx, sy;
    r  = '0;
    np = active_workers();
    w  = cfg_width;
    h  = cfg_height;
    if (w > MAX_RASTER_DIM) w = MAX_RASTER_DIM;
    if (h > MAX_RASTER_DIM) h = MAX_RASTER_DIM;
    if (int'(rank) >= np) begin
      r.rank_error = 1'b1;
      return r;
    end
    rows = 0;
    while ((rows + 1) * (rows + 1) <= np) rows++;
    while (rows > 1 && np % rows != 0) rows--;
    cols = np / rows;
    place_block(int'(rank) % cols, cols, w, cfg_split, ox, sx);
    place_block(int'(rank) / cols, rows, h, cfg_split, oy, sy);
    r.offset_x  = ox[DIM_W-1:0];
    r.offset_y  = oy[DIM_W-1:0];
    r.size_x    = sx[DIM_W-1:0];
    r.size_y    = sy[DIM_W-1:0];
    r.grid_cols = cols[NP_W-1:0];
    r.grid_rows = rows[NP_W-1:0];
    return r;
  endfunction

  always @(negedge clk_i) begin
    if (quiet) begin
      m_axis_tready_i = 1'b1;
    end else if (stall_left > 0) begin
      m_axis_tready_i = 1'b0;
      stall_left--;
    end else if ($urandom_range(99) < 3) begin
      m_axis_tready_i = 1'b0;
      stall_left = $urandom_range(0, 3);
    end else begin
      m_axis_tready_i = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_blocks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: data=%h user=%b", m_axis_tdata_o, m_axis_tuser_o);
      end else begin
        want = expected_blocks.pop_front();
        if (m_axis_tuser_o !== want.rank_error ||
            m_axis_tdata_o[15:0] !== want.offset_x ||
            m_axis_tdata_o[31:16] !== want.offset_y ||
            m_axis_tdata_o[47:32] !== want.size_x ||
            m_axis_tdata_o[63:48] !== want.size_y ||
            m_axis_tdata_o[76:64] !== want.grid_cols ||
            m_axis_tdata_o[89:77] !== want.grid_rows) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp: ox=%0d oy=%0d sx=%0d sy=%0d cols=%0d rows=%0d err=%0b",
                     want.offset_x, want.offset_y, want.size_x, want.size_y,
                     want.grid_cols, want.grid_rows, want.rank_error);
            $display("         got: ox=%0d oy=%0d sx=%0d sy=%0d cols=%0d rows=%0d err=%0b",
                     m_axis_tdata_o[15:0], m_axis_tdata_o[31:16], m_axis_tdata_o[47:32],
                     m_axis_tdata_o[63:48], m_axis_tdata_o[76:64], m_axis_tdata_o[89:77],
                     m_axis_tuser_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results pending",
               idle_cycles, expected_blocks.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_rank(input logic [RANK_W-1:0] rank);
    res_t want;
    if (!quiet && $urandom_range(99) < 7) begin
      s_axis_tvalid_i = 1'b0;
      repeat ($urandom_range(1, 25)) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = {{(IN_DATA_W - RANK_W){1'b0}}, rank};
    do @(posedge clk_i); while (!s_axis_tready_o);
    want = predict_block(rank);
    expected_blocks.push_back(want);
    words_sent++;
    if (want.rank_error) error_words++;
    @(negedge clk_i);
  endtask

  task automatic send_random_rank();
    int np;
    np = active_workers();
    if (np > 0 && $urandom_range(99) < 80)
      send_rank(RANK_W'($urandom_range(0, np - 1)));
    else
      send_rank(RANK_W'($urandom_range(0, (1 << RANK_W) - 1)));
  endtask

  task automatic drain_results();
    s_axis_tvalid_i = 1'b0;
    while (expected_blocks.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_WORKER_COUNT:  cfg_workers = value[NP_W-1:0];
      REG_RASTER_WIDTH:  cfg_width   = value;
      REG_RASTER_HEIGHT: cfg_height  = value;
      REG_SPLIT_MODE:    cfg_split   = value[0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] workers, input logic [CFG_DATA_W-1:0] w,
                           input logic [CFG_DATA_W-1:0] h, input logic mode);
    drain_results();
    write_reg(REG_WORKER_COUNT, workers);
    write_reg(REG_RASTER_WIDTH, w);
    write_reg(REG_RASTER_HEIGHT, h);
    write_reg(REG_SPLIT_MODE, {{(CFG_DATA_W - 1){1'b0}}, mode});
    config_phases++;
  endtask

  function automatic logic [CFG_DATA_W-1:0] random_dim();
    case ($urandom_range(0, 7))
      0:       return CFG_DATA_W'($urandom_range(0, 65535));
      1:       return CFG_DATA_W'($urandom_range(0, 8));
      default: return CFG_DATA_W'($urandom_range(1, 2000));
    endcase
  endfunction

  task automatic configure_random();
    logic [CFG_DATA_W-1:0] workers;
    case ($urandom_range(0, 9))
      0:       workers = '0;
      1:       workers = CFG_DATA_W'($urandom_range(0, 65535));
      2, 3:    workers = CFG_DATA_W'($urandom_range(1, MAX_WORKERS));
      default: workers = CFG_DATA_W'($urandom_range(1, 64));
    endcase
    configure(workers, random_dim(), random_dim(), 1'($urandom_range(0, 1)));
  endtask

  task automatic test_reset_defaults();
    send_rank(12'd0);
    send_rank(12'd1);
    send_rank(12'hFFF);
  endtask

  task automatic test_remainder_modes();
    configure(16'd12, 16'd65535, 16'd65534, 1'b0);
    send_rank(12'd0);
    send_rank(12'd11);
    send_rank(12'd5);
    configure(16'd12, 16'd65535, 16'd65534, 1'b1);
    send_rank(12'd0);
    send_rank(12'd11);
    send_rank(12'd5);
  endtask

  task automatic test_edge_configs();
    configure(16'd0, 16'd100, 16'd100, 1'b0);
    send_rank(12'd0);
    configure(16'd4096, 16'd100, 16'd7, 1'b0);
    send_rank(12'hFFF);
    send_rank(12'd0);
    configure(16'd4096, 16'd100, 16'd7, 1'b1);
    send_rank(12'hFFF);
    send_rank(12'd3);
    configure(16'hFFFF, 16'd65535, 16'd65535, 1'b1);
    send_rank(12'hFFF);
    send_rank(12'd2048);
    configure(16'd4093, 16'd65535, 16'd1, 1'b0);
    send_rank(12'd4092);
    send_rank(12'd4093);
    configure(16'd6, 16'd0, 16'd0, 1'b0);
    send_rank(12'd5);
    configure(16'd6, 16'd0, 16'd0, 1'b1);
    send_rank(12'd5);
  endtask

  task automatic test_random_phases(input int count);
    int  target;
    int  phase_len;
    bit  paused;
    target = words_sent + count;
    paused = 1'b0;
    while (words_sent < target) begin
      configure_random();
      phase_len = $urandom_range(10, 40);
      for (int i = 0; i < phase_len && words_sent < target; i++) begin
        if (!paused && words_sent > target - count / 2) begin
          drain_results();
          paused = 1'b1;
        end
        send_random_rank();
      end
    end
  endtask

  task automatic test_quiet_stretch(input int count);
    quiet = 1'b1;
    configure_random();
    repeat (count) send_random_rank();
    drain_results();
    quiet = 1'b0;
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = REG_WORKER_COUNT;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    quiet           = 1'b0;
    mismatches      = 0;
    words_sent      = 0;
    error_words     = 0;
    config_phases   = 0;
    cfg_workers     = NP_W'(1);
    cfg_width       = DIM_W'(1);
    cfg_height      = DIM_W'(1);
    cfg_split       = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_remainder_modes();
    test_edge_configs();
    test_random_phases(360);
    test_quiet_stretch(40);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d rank queries (%0d out of range) over %0d register settings",
             words_sent, error_words, config_phases);
    $display("both split modes, zero and saturated worker counts, empty and full rasters");
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/rbd_pkg.sv
src/rbd_divider.sv
src/rbd_datapath.sv
src/rbd_ctrl.sv
src/raster_block_decomposition_unit.sv
src/rbd_checker.sv
sim/raster_block_decomposition_unit_test.sv
